/* hdl/bplg_pkg.sv */
// shared types and constants of the line pixel generator
package bplg_pkg;

   localparam int REG_BITS  = 13;
   localparam int ADDR_BITS = 24;

   localparam logic [REG_BITS-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [REG_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

endpackage

/* hdl/bplg_core.sv */
// line state registers; start sets up, busy advance steps once
module bplg_core #(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      mid_free,
   input  logic                      operation,
   input  logic [COORD_BITS-1:0]     x_start,
   input  logic [COORD_BITS-1:0]     y_start,
   input  logic [COORD_BITS-1:0]     x_end,
   input  logic [COORD_BITS-1:0]     y_end,
   output bplg_pkg::stage_ctl_type   ctl,
   output logic                      busy,
   output logic [COORD_BITS-1:0]     cur_x,
   output logic [COORD_BITS-1:0]     cur_y
);

   localparam int ERR_BITS = COORD_BITS + 2;

   logic [COORD_BITS-1:0]      cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]      cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]      major_end_ff, major_end_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic [COORD_BITS-1:0]      abs_dx_ff, abs_dx_in;
   logic [COORD_BITS-1:0]      abs_dy_ff, abs_dy_in;
   logic                       y_major_ff, y_major_in;
   logic                       minor_inc_ff, minor_inc_in;
   logic                       busy_ff, busy_in;
   logic                       valid_ff, valid_in;

   logic signed [COORD_BITS:0] dx, dy;
   logic [COORD_BITS-1:0]      adx, ady;
   logic                       produce;
   logic                       err_neg, err_zero;
   logic                       last_new;

   always_comb begin
      dx  = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
      dy  = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
      adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      err_neg  = err_ff[ERR_BITS-1];
      err_zero = (err_ff == '0);

      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      major_end_in = major_end_ff;
      err_in       = err_ff;
      abs_dx_in    = abs_dx_ff;
      abs_dy_in    = abs_dy_ff;
      y_major_in   = y_major_ff;
      minor_inc_in = minor_inc_ff;
      produce      = 1'b0;

      if (accept) begin
         if (operation == bplg_pkg::OP_START) begin
            produce      = 1'b1;
            abs_dx_in    = adx;
            abs_dy_in    = ady;
            y_major_in   = ady > adx;
            minor_inc_in = (dx[COORD_BITS] && dy[COORD_BITS]) ||
                           (!dx[COORD_BITS] && dx != '0 && !dy[COORD_BITS] && dy != '0);
            if (!(ady > adx)) begin
               if (!dx[COORD_BITS]) begin
                  cur_x_in = x_start; cur_y_in = y_start; major_end_in = x_end;
               end else begin
                  cur_x_in = x_end; cur_y_in = y_end; major_end_in = x_start;
               end
               err_in = $signed({1'b0, ady, 1'b0}) - $signed(ERR_BITS'(adx));
            end else begin
               if (!dy[COORD_BITS]) begin
                  cur_x_in = x_start; cur_y_in = y_start; major_end_in = y_end;
               end else begin
                  cur_x_in = x_end; cur_y_in = y_end; major_end_in = y_start;
               end
               err_in = $signed({1'b0, adx, 1'b0}) - $signed(ERR_BITS'(ady));
            end
         end else if (busy_ff) begin
            produce = 1'b1;
            if (!y_major_ff) begin
               cur_x_in = cur_x_ff + COORD_BITS'(1);
               if (err_neg) begin
                  err_in = err_ff + $signed({1'b0, abs_dy_ff, 1'b0});
               end else begin
                  cur_y_in = minor_inc_ff ? cur_y_ff + COORD_BITS'(1)
                                          : cur_y_ff - COORD_BITS'(1);
                  err_in   = err_ff + $signed({1'b0, abs_dy_ff, 1'b0})
                                    - $signed({1'b0, abs_dx_ff, 1'b0});
               end
            end else begin
               cur_y_in = cur_y_ff + COORD_BITS'(1);
               if (err_neg || err_zero) begin
                  err_in = err_ff + $signed({1'b0, abs_dx_ff, 1'b0});
               end else begin
                  cur_x_in = minor_inc_ff ? cur_x_ff + COORD_BITS'(1)
                                          : cur_x_ff - COORD_BITS'(1);
                  err_in   = err_ff + $signed({1'b0, abs_dx_ff, 1'b0})
                                    - $signed({1'b0, abs_dy_ff, 1'b0});
               end
            end
         end
      end

      last_new = ((y_major_in ? cur_y_in : cur_x_in) == major_end_in);
      busy_in  = produce ? !last_new : busy_ff;
      valid_in = produce ? 1'b1 : (mid_free ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         major_end_ff <= '0;
         err_ff       <= '0;
         abs_dx_ff    <= '0;
         abs_dy_ff    <= '0;
         y_major_ff   <= 1'b0;
         minor_inc_ff <= 1'b0;
         busy_ff      <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         major_end_ff <= major_end_in;
         err_ff       <= err_in;
         abs_dx_ff    <= abs_dx_in;
         abs_dy_ff    <= abs_dy_in;
         y_major_ff   <= y_major_in;
         minor_inc_ff <= minor_inc_in;
         busy_ff      <= busy_in;
         valid_ff     <= valid_in;
      end
   end

   assign ctl.valid = valid_ff;
   assign ctl.last  = !busy_ff;
   assign busy      = busy_ff;
   assign cur_x     = cur_x_ff;
   assign cur_y     = cur_y_ff;

endmodule

/* hdl/bplg_addr.sv */
// frame bounds check, frame buffer address and result register
module bplg_addr #(
   parameter int COORD_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  bplg_pkg::stage_ctl_type            ctl,
   input  logic [COORD_BITS-1:0]              cur_x,
   input  logic [COORD_BITS-1:0]              cur_y,
   input  logic [bplg_pkg::REG_BITS-1:0]      frame_width,
   input  logic [bplg_pkg::REG_BITS-1:0]      frame_height,
   output logic                               rsp_valid,
   output logic [COORD_BITS-1:0]              rsp_pixel_x,
   output logic [COORD_BITS-1:0]              rsp_pixel_y,
   output logic [bplg_pkg::ADDR_BITS-1:0]     rsp_pixel_address,
   output logic                               rsp_in_frame,
   output logic                               rsp_last_pixel
);

   localparam int RB       = bplg_pkg::REG_BITS;
   localparam int CMP_BITS = (COORD_BITS > RB) ? COORD_BITS : RB;

   logic [CMP_BITS-1:0]              x_ext, y_ext, w_ext, h_ext, row_wide;
   logic [RB-1:0]                    row, x_low;
   logic [2*RB-1:0]                  product, sum;
   logic                             in_bounds;

   logic                             valid_ff;
   logic [COORD_BITS-1:0]            x_ff, y_ff;
   logic [bplg_pkg::ADDR_BITS-1:0]   addr_ff, addr_in;
   logic                             inside_ff, last_ff;

   always_comb begin
      x_ext     = CMP_BITS'(cur_x);
      y_ext     = CMP_BITS'(cur_y);
      w_ext     = CMP_BITS'(frame_width);
      h_ext     = CMP_BITS'(frame_height);
      in_bounds = (x_ext < w_ext) && (y_ext < h_ext);
      row_wide  = h_ext - CMP_BITS'(1) - y_ext;
      row       = row_wide[RB-1:0];
      x_low     = x_ext[RB-1:0];
      product   = (2*RB)'(row) * (2*RB)'(frame_width);
      sum       = product + (2*RB)'(x_low);
      addr_in   = in_bounds ? sum[bplg_pkg::ADDR_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff      <= cur_x;
         y_ff      <= cur_y;
         addr_ff   <= addr_in;
         inside_ff <= in_bounds;
         last_ff   <= ctl.last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pixel_x       = x_ff;
   assign rsp_pixel_y       = y_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_in_frame      = inside_ff;
   assign rsp_last_pixel    = last_ff;

endmodule

/* hdl/bresenham_line_pixel_generator_unit.sv */
// top level of the bresenham line pixel generator
// an accepted word passes through the line state registers and then the result register to the rsp side
// throughput: one word per cycle while req_stall is low; the line state update is a registered loop
// the address stage holds one multiply by the frame width
// an advance with no active line yields no pixel
// synchronous reset: no line active, frame 640 by 480, no pixel pending
module bresenham_line_pixel_generator_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic [COORD_BITS-1:0]              req_x_start,
   input  logic [COORD_BITS-1:0]              req_y_start,
   input  logic [COORD_BITS-1:0]              req_x_end,
   input  logic [COORD_BITS-1:0]              req_y_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [COORD_BITS-1:0]              rsp_pixel_x,
   output logic [COORD_BITS-1:0]              rsp_pixel_y,
   output logic [bplg_pkg::ADDR_BITS-1:0]     rsp_pixel_address,
   output logic                               rsp_in_frame,
   output logic                               rsp_last_pixel,
   input  logic                               csr_write_enable,
   input  logic [0:0]                         csr_index,
   input  logic [bplg_pkg::REG_BITS-1:0]      csr_write_data
);

   logic [bplg_pkg::REG_BITS-1:0] frame_width_ff, frame_height_ff;
   logic                          out_free, mid_free, accept, busy;
   bplg_pkg::stage_ctl_type       mid_ctl;
   logic [COORD_BITS-1:0]         cur_x, cur_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bplg_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= bplg_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (bplg_pkg::csr_index_type'(csr_index))
            bplg_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data;
            bplg_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid || !rsp_stall;
   assign mid_free  = !mid_ctl.valid || out_free;
   assign req_stall = !mid_free;
   assign accept    = req_valid && mid_free;

   bplg_core #(.COORD_BITS(COORD_BITS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mid_free  (mid_free),
      .operation (req_operation),
      .x_start   (req_x_start),
      .y_start   (req_y_start),
      .x_end     (req_x_end),
      .y_end     (req_y_end),
      .ctl       (mid_ctl),
      .busy      (busy),
      .cur_x     (cur_x),
      .cur_y     (cur_y)
   );

   bplg_addr #(.COORD_BITS(COORD_BITS)) u_addr (
      .clock             (clock),
      .reset             (reset),
      .load              (out_free),
      .ctl               (mid_ctl),
      .cur_x             (cur_x),
      .cur_y             (cur_y),
      .frame_width       (frame_width_ff),
      .frame_height      (frame_height_ff),
      .rsp_valid         (rsp_valid),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_in_frame      (rsp_in_frame),
      .rsp_last_pixel    (rsp_last_pixel)
   );

   // advance with no active line produces nothing
   assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == bplg_pkg::OP_ADVANCE && !busy |=> !mid_ctl.valid)
      else $error("pixel produced by advance while idle");

   // a pending pixel moves to the result register when it is free
   assert property (@(posedge clock) disable iff (reset)
      mid_ctl.valid && out_free |=> rsp_valid)
      else $error("pixel lost between stages");

   // out of frame pixels carry a zero address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_frame |-> rsp_pixel_address == '0)
      else $error("nonzero address on out of frame pixel");

endmodule
